// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TFN_ASSERT_NOW(lbl, clk, rst_n, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define TFN_ASSERT_NEXT(lbl, clk, rst_n, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/tfn_pkg.sv =====
// Package: constants and types for the triangle face normal pipeline
`timescale 1ns / 1ps
`default_nettype none
package tfn_pkg;
    localparam int COORD_WIDTH_DEF      = 24;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int CFG_W                = 32;
    localparam logic [CFG_W-1:0] MIN_LENGTH_RESET = 32'd4295;
    localparam int SW                   = 31;   // normalised component width
    localparam int SQ_W                 = 64;   // radicand width
    localparam int ROOT_W               = 32;
    localparam int OUT_W                = 16;

    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } tfn_side_t;

    typedef struct packed {
        logic [2:0][SW-1:0] s;
        tfn_side_t          side;
    } tfn_carry_t;
endpackage
`default_nettype wire

// ===== design/tfn_if.sv =====
// Interfaces: triangle, normal and configuration channels
`timescale 1ns / 1ps
`default_nettype none
interface tfn_tri_if #(parameter int CW = 24);
    logic valid;
    logic ready;
    logic signed [CW-1:0] v0_x;
    logic signed [CW-1:0] v0_y;
    logic signed [CW-1:0] v0_z;
    logic signed [CW-1:0] v1_x;
    logic signed [CW-1:0] v1_y;
    logic signed [CW-1:0] v1_z;
    logic signed [CW-1:0] v2_x;
    logic signed [CW-1:0] v2_y;
    logic signed [CW-1:0] v2_z;
    modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                    input ready);
    modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                    output ready);
endinterface

interface tfn_nrm_if;
    logic valid;
    logic ready;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               degenerate;
    modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

interface tfn_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] min_length;
    modport source (output valid, min_length, input ready);
    modport sink   (input valid, min_length, output ready);
endinterface
`default_nettype wire

// ===== design/tfn_cross.sv =====
// Edge vectors, products and cross product magnitude (three stages)
`timescale 1ns / 1ps
`default_nettype none
module tfn_cross #(
    parameter int CW = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] coord [9],
    output logic                 out_valid,
    output logic [2*CW+1:0]      mag [3],
    output logic [2:0]           neg
);
    localparam int EW = CW + 1;
    localparam int PW = 2 * EW;

    logic signed [EW-1:0] e_reg [6];
    logic signed [EW-1:0] e_next [6];
    logic signed [PW-1:0] p_reg [6];
    logic signed [PW-1:0] p_next [6];
    logic signed [PW:0]   c [3];
    logic [PW-1:0]        mag_reg [3];
    logic [PW-1:0]        mag_next [3];
    logic [2:0]           neg_reg;
    logic [2:0]           neg_next;
    logic                 va_reg, vb_reg, vc_reg;

    always_comb
    begin
        e_next[0] = EW'(coord[3]) - EW'(coord[0]);
        e_next[1] = EW'(coord[4]) - EW'(coord[1]);
        e_next[2] = EW'(coord[5]) - EW'(coord[2]);
        e_next[3] = EW'(coord[6]) - EW'(coord[0]);
        e_next[4] = EW'(coord[7]) - EW'(coord[1]);
        e_next[5] = EW'(coord[8]) - EW'(coord[2]);
        p_next[0] = PW'(e_reg[1]) * PW'(e_reg[5]);
        p_next[1] = PW'(e_reg[2]) * PW'(e_reg[4]);
        p_next[2] = PW'(e_reg[2]) * PW'(e_reg[3]);
        p_next[3] = PW'(e_reg[0]) * PW'(e_reg[5]);
        p_next[4] = PW'(e_reg[0]) * PW'(e_reg[4]);
        p_next[5] = PW'(e_reg[1]) * PW'(e_reg[3]);
        c[0] = (PW+1)'(p_reg[0]) - (PW+1)'(p_reg[1]);
        c[1] = (PW+1)'(p_reg[2]) - (PW+1)'(p_reg[3]);
        c[2] = (PW+1)'(p_reg[4]) - (PW+1)'(p_reg[5]);
        for (int i = 0; i < 3; i++)
        begin
            neg_next[i] = c[i][PW];
            mag_next[i] = PW'(c[i][PW] ? -c[i] : c[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg   <= e_next;
            p_reg   <= p_next;
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
    end

    assign out_valid = vc_reg;
    assign mag       = mag_reg;
    assign neg       = neg_reg;
endmodule
`default_nettype wire

// ===== design/tfn_prep.sv =====
// Threshold test and scaling to 31 bits, then sum of squares (four stages)
`timescale 1ns / 1ps
`default_nettype none
module tfn_prep #(
    parameter int MW = 50
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [MW-1:0]        mag [3],
    input  logic [2:0]           neg,
    input  logic [31:0]          min_length,
    output logic                 out_valid,
    output logic [63:0]          radicand,
    output tfn_pkg::tfn_carry_t  carry
);
    import tfn_pkg::*;

    localparam int BW  = $clog2(MW + 1);
    localparam int SHW = MW + SW;

    logic [MW-1:0]   orv;
    logic [BW-1:0]   b_next, b_reg;
    logic            big_reg;
    logic [SQ_W-1:0] sq_reg [3];
    logic [SQ_W-1:0] m2_reg;
    logic [MW-1:0]   a_reg [3];
    logic [2:0]      negd_reg;
    logic [SQ_W+1:0] s_sum;
    logic [SHW-1:0]  sh [3];
    tfn_carry_t      ce_next, ce_reg, cf_reg;
    logic [2*SW-1:0] q2_reg [3];
    logic [SQ_W-1:0] sum_reg;
    tfn_carry_t      cg_reg;
    logic            vd_reg, ve_reg, vf_reg, vg_reg;

    always_comb
    begin
        orv    = mag[0] | mag[1] | mag[2];
        b_next = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (orv[i])
                b_next = BW'(i + 1);
        end
    end

    always_comb
    begin
        s_sum = (SQ_W+2)'(sq_reg[0]) + (SQ_W+2)'(sq_reg[1]) + (SQ_W+2)'(sq_reg[2]);
        ce_next.side.neg   = negd_reg;
        ce_next.side.degen = !big_reg && (s_sum <= (SQ_W+2)'(m2_reg));
        for (int i = 0; i < 3; i++)
        begin
            if (int'(b_reg) >= SW)
                sh[i] = SHW'(a_reg[i]) >> (int'(b_reg) - SW);
            else
                sh[i] = SHW'(a_reg[i]) << (SW - int'(b_reg));
            ce_next.s[i] = SW'(sh[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
        end
        else if (en)
        begin
            vd_reg <= in_valid;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
            vg_reg <= vf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m2_reg <= SQ_W'(min_length) * SQ_W'(min_length);
        if (en)
        begin
            b_reg    <= b_next;
            big_reg  <= int'(b_next) > 32;
            a_reg    <= mag;
            negd_reg <= neg;
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= SQ_W'(32'(mag[i])) * SQ_W'(32'(mag[i]));
            ce_reg <= ce_next;
            cf_reg <= ce_reg;
            for (int i = 0; i < 3; i++)
                q2_reg[i] <= (2*SW)'(ce_reg.s[i]) * (2*SW)'(ce_reg.s[i]);
            sum_reg <= SQ_W'(q2_reg[0]) + SQ_W'(q2_reg[1]) + SQ_W'(q2_reg[2]);
            cg_reg  <= cf_reg;
        end
    end

    assign out_valid = vg_reg;
    assign radicand  = sum_reg;
    assign carry     = cg_reg;
endmodule
`default_nettype wire

// ===== design/tfn_isqrt.sv =====
// Integer square root, one result bit per pipeline stage
`timescale 1ns / 1ps
`default_nettype none
module tfn_isqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [63:0]         radicand,
    input  tfn_pkg::tfn_carry_t carry_in,
    output logic                out_valid,
    output logic [31:0]         root,
    output tfn_pkg::tfn_carry_t carry_out
);
    import tfn_pkg::*;

    localparam int NST = ROOT_W;

    logic [SQ_W-1:0] rem_reg  [NST];
    logic [SQ_W-1:0] root_reg [NST];
    tfn_carry_t      c_reg    [NST];
    logic            v_reg    [NST];

    for (genvar k = 0; k < NST; k++)
    begin : g_stage
        localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        logic [SQ_W-1:0] rem_in, root_in, trial, rem_next, root_next;
        tfn_carry_t      c_in;
        logic            v_in, ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = radicand;
            assign root_in = '0;
            assign c_in    = carry_in;
            assign v_in    = in_valid;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign c_in    = c_reg[k-1];
            assign v_in    = v_reg[k-1];
        end

        always_comb
        begin
            trial     = root_in + BITV;
            ge        = rem_in >= trial;
            rem_next  = ge ? rem_in - trial : rem_in;
            root_next = ge ? (root_in >> 1) + BITV : root_in >> 1;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                c_reg[k]    <= c_in;
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign root      = ROOT_W'(root_reg[NST-1]);
    assign carry_out = c_reg[NST-1];
endmodule
`default_nettype wire

// ===== design/tfn_div.sv =====
// Rounded division of three components by the length, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module tfn_div #(
    parameter int FB = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [31:0]         len,
    input  tfn_pkg::tfn_carry_t carry,
    output logic                out_valid,
    output logic [FB:0]         quot [3],
    output tfn_pkg::tfn_side_t  side
);
    import tfn_pkg::*;

    localparam int QB = FB + 1;
    localparam int NW = FB + 32;

    logic [ROOT_W-1:0] rem_reg [QB+1][3];
    logic [QB-1:0]     num_reg [QB+1][3];
    logic [ROOT_W-1:0] len_reg [QB+1];
    tfn_side_t         side_reg [QB+1];
    logic              v_reg [QB+1];
    logic [NW-1:0]     n_full [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            n_full[i] = (NW'(carry.s[i]) << FB) + NW'(len >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= ROOT_W'(n_full[i] >> QB);
                num_reg[0][i] <= QB'(n_full[i]);
            end
            len_reg[0]  <= len;
            side_reg[0] <= carry.side;
        end
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_stage
        logic [ROOT_W-1:0] rem_next [3];
        logic [QB-1:0]     num_next [3];
        logic [ROOT_W:0]   t [3];
        logic [2:0]        ge;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                t[i]        = {rem_reg[j][i], num_reg[j][i][QB-1]};
                ge[i]       = t[i] >= {1'b0, len_reg[j]};
                rem_next[i] = ROOT_W'(ge[i] ? t[i] - {1'b0, len_reg[j]} : t[i]);
                num_next[i] = {num_reg[j][i][QB-2:0], ge[i]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j+1] <= 1'b0;
            else if (en)
                v_reg[j+1] <= v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]  <= rem_next;
                num_reg[j+1]  <= num_next;
                len_reg[j+1]  <= len_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign out_valid = v_reg[QB];
    assign quot      = num_reg[QB];
    assign side      = side_reg[QB];
endmodule
`default_nettype wire

// ===== design/triangle_face_normal.sv =====
// Top level: triangle face normal pipeline with output register
//
// channel   dir  payload                                     beat when
// triangle  in   v0_x..v2_z, COORD_WIDTH signed each          valid & ready
// normal    out  normal_x/y/z (16b signed), degenerate        valid & ready
// cfg       in   min_length (32b unsigned)                    valid & ready
//
// One triangle per cycle sustained unless a held output stalls the pipeline. Stages, in
// order: cross product, scaling, square root, division, output register.
// The square root stages (one root bit each) set most of the latency.
// Reset clears valid bits and loads min_length with its default; no clearing pass.
// A held output stalls the pipeline only when its last stage holds a beat.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module triangle_face_normal #(
    parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    tfn_tri_if.sink triangle,
    tfn_nrm_if.source normal,
    tfn_cfg_if.sink cfg
);
    import tfn_pkg::*;

    localparam int MW = 2 * COORD_WIDTH + 2;
    localparam int QB = NORMAL_FRAC_BITS + 1;

    logic [CFG_W-1:0]       min_length_reg;
    logic                   en;
    logic signed [COORD_WIDTH-1:0] coord [9];
    logic                   x_valid, p_valid, r_valid, d_valid;
    logic [MW-1:0]          mag [3];
    logic [2:0]             neg;
    logic [SQ_W-1:0]        radicand;
    tfn_carry_t             p_carry, r_carry;
    logic [ROOT_W-1:0]      root;
    logic [QB-1:0]          quot [3];
    tfn_side_t              d_side;
    logic                   out_load;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]       nrm_reg [3];
    logic [OUT_W-1:0]       nrm_next [3];
    logic                   degen_reg;

    assign coord = '{triangle.v0_x, triangle.v0_y, triangle.v0_z,
                     triangle.v1_x, triangle.v1_y, triangle.v1_z,
                     triangle.v2_x, triangle.v2_y, triangle.v2_z};

    assign out_load       = d_valid && (normal.ready || !out_valid_reg);
    assign en             = normal.ready || !out_valid_reg || !d_valid;
    assign triangle.ready = en;
    assign cfg.ready      = 1'b1;

    tfn_cross #(.CW(COORD_WIDTH)) u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (triangle.valid),
        .coord     (coord),
        .out_valid (x_valid),
        .mag       (mag),
        .neg       (neg)
    );

    tfn_prep #(.MW(MW)) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (x_valid),
        .mag        (mag),
        .neg        (neg),
        .min_length (min_length_reg),
        .out_valid  (p_valid),
        .radicand   (radicand),
        .carry      (p_carry)
    );

    tfn_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_valid),
        .radicand  (radicand),
        .carry_in  (p_carry),
        .out_valid (r_valid),
        .root      (root),
        .carry_out (r_carry)
    );

    tfn_div #(.FB(NORMAL_FRAC_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .len       (root),
        .carry     (r_carry),
        .out_valid (d_valid),
        .quot      (quot),
        .side      (d_side)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (d_side.degen)
                nrm_next[i] = '0;
            else if (d_side.neg[i])
                nrm_next[i] = OUT_W'(0) - OUT_W'(quot[i]);
            else
                nrm_next[i] = OUT_W'(quot[i]);
        end
        if (out_load)
            out_valid_next = 1'b1;
        else if (normal.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            min_length_reg <= MIN_LENGTH_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
                min_length_reg <= cfg.min_length;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            nrm_reg   <= nrm_next;
            degen_reg <= d_side.degen;
        end
    end

    assign normal.valid      = out_valid_reg;
    assign normal.normal_x   = nrm_reg[0];
    assign normal.normal_y   = nrm_reg[1];
    assign normal.normal_z   = nrm_reg[2];
    assign normal.degenerate = degen_reg;

    `TFN_ASSERT_NOW(a_degen_zero, clk, rst_n, normal.valid && normal.degenerate,
        normal.normal_x == 16'sd0 && normal.normal_y == 16'sd0 && normal.normal_z == 16'sd0)
    `TFN_ASSERT_NOW(a_full_stall, clk, rst_n, normal.valid && !normal.ready && d_valid,
        !triangle.ready)
    `TFN_ASSERT_NEXT(a_cfg_write, clk, rst_n, cfg.valid && cfg.ready,
        min_length_reg == $past(cfg.min_length))
endmodule
`default_nettype wire
